@@ design/mf3_pkg.sv @@
`timescale 1ns / 1ps

package mf3_pkg;

  // frame geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 3;

  localparam int PIX_W = 8;
  localparam int DIM_W = 11;
  localparam int POS_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  localparam int TAPS        = 9;
  localparam int MEDIAN_RANK = 4;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  // skid queue between window build and sorter
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [TAPS-1:0][PIX_W-1:0] taps_t;

  typedef struct packed {
    taps_t            taps;
    logic [POS_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             eof;
  } win_item_t;

endpackage

@@ design/mf3_front.sv @@
`timescale 1ns / 1ps

module mf3_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [mf3_pkg::DIM_W-1:0]        image_width,
  input  logic [mf3_pkg::DIM_W-1:0]        image_height,
  input  logic                             pixel_valid,
  output logic                             pixel_ready,
  input  logic [mf3_pkg::PIX_W-1:0]        pixel_value,
  input  logic                             frame_start,
  output logic                             push,
  output mf3_pkg::win_item_t               push_item,
  input  logic                             queue_full
);

  localparam int PW = mf3_pkg::PIX_W;
  localparam int CW = mf3_pkg::POS_W;
  localparam int RW = mf3_pkg::ROW_W;
  localparam int DW = mf3_pkg::DIM_W;

  logic [DW-1:0] width_c, height_c;
  logic [CW-1:0] last_col_idx, col_in, col;
  logic [RW-1:0] last_row_idx, row_in, row;
  logic          last_col, last_row, accept;

  logic [CW-1:0] col_pos, col_pos_next;
  logic [RW-1:0] row_pos, row_pos_next;

  // item held while its line store reads come back
  logic          b_valid, b_emit, b_eof, b_adv;
  logic [PW-1:0] b_px, b_top, b_mid;
  logic [CW-1:0] b_col;
  logic [RW-1:0] b_row;

  logic [PW-1:0] older_mem [mf3_pkg::MAX_WIDTH];
  logic [PW-1:0] newer_mem [mf3_pkg::MAX_WIDTH];
  logic [PW-1:0] older_rd, newer_rd;

  // bypass for a read of the entry being written in the same cycle
  logic          fwd;
  logic [PW-1:0] fwd_top, fwd_mid;

  logic [PW-1:0] win [6];

  always_comb begin
    if (image_width < DW'(mf3_pkg::MIN_DIM)) width_c = DW'(mf3_pkg::MIN_DIM);
    else if (image_width > DW'(mf3_pkg::MAX_WIDTH)) width_c = DW'(mf3_pkg::MAX_WIDTH);
    else width_c = image_width;
    if (image_height < DW'(mf3_pkg::MIN_DIM)) height_c = DW'(mf3_pkg::MIN_DIM);
    else if (image_height > DW'(mf3_pkg::MAX_HEIGHT)) height_c = DW'(mf3_pkg::MAX_HEIGHT);
    else height_c = image_height;
    last_col_idx = CW'(width_c - DW'(1));
    last_row_idx = RW'(height_c - DW'(1));

    col_in = frame_start ? '0 : col_pos;
    row_in = frame_start ? '0 : row_pos;
    col    = (col_in > last_col_idx) ? last_col_idx : col_in;
    row    = (row_in > last_row_idx) ? last_row_idx : row_in;
    last_col = (col == last_col_idx);
    last_row = (row == last_row_idx);

    if (last_col) begin
      col_pos_next = '0;
      row_pos_next = last_row ? '0 : row + RW'(1);
    end else begin
      col_pos_next = col + CW'(1);
      row_pos_next = row;
    end
  end

  assign b_adv       = b_valid && !queue_full;
  assign pixel_ready = !b_valid || !queue_full;
  assign accept      = pixel_valid && pixel_ready;

  assign b_top = fwd ? fwd_top : older_rd;
  assign b_mid = fwd ? fwd_mid : newer_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      b_valid <= 1'b0;
      fwd     <= 1'b0;
    end else begin
      if (accept) begin
        col_pos <= col_pos_next;
        row_pos <= row_pos_next;
        fwd     <= b_adv && (b_col == col);
      end
      if (accept) b_valid <= 1'b1;
      else if (b_adv) b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_px    <= pixel_value;
      b_col   <= col;
      b_row   <= row;
      b_emit  <= (col >= CW'(2)) && (row >= RW'(2));
      b_eof   <= last_col && last_row;
      fwd_top <= b_mid;
      fwd_mid <= b_px;
    end
  end

  // line stores: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (b_adv) begin
      older_mem[b_col] <= b_mid;
      newer_mem[b_col] <= b_px;
    end
    if (accept) begin
      older_rd <= older_mem[col];
      newer_rd <= newer_mem[col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else if (b_adv) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= b_top;
      win[4] <= b_mid;
      win[5] <= b_px;
    end
  end

  assign push             = b_adv && b_emit;
  assign push_item.taps   = {b_px, b_mid, b_top, win[5], win[4], win[3], win[2], win[1], win[0]};
  assign push_item.column = b_col - CW'(2);
  assign push_item.row    = b_row - RW'(2);
  assign push_item.eof    = b_eof;

endmodule

@@ design/mf3_queue.sv @@
`timescale 1ns / 1ps

module mf3_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mf3_pkg::win_item_t push_item,
  output logic               full,
  output logic               pop_valid,
  output mf3_pkg::win_item_t pop_item,
  input  logic               pop
);

  mf3_pkg::win_item_t entries [mf3_pkg::QUEUE_DEPTH];
  logic [mf3_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [mf3_pkg::QCNT_W-1:0] count;
  logic                       do_pop;

  assign full      = (count == mf3_pkg::QCNT_W'(mf3_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = entries[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + mf3_pkg::QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + mf3_pkg::QPTR_W'(1);
      if (push && !do_pop) count <= count + mf3_pkg::QCNT_W'(1);
      else if (do_pop && !push) count <= count - mf3_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

endmodule

@@ design/mf3_back.sv @@
`timescale 1ns / 1ps

module mf3_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  mf3_pkg::win_item_t         q_item,
  output logic                       q_pop,
  output logic                       median_valid,
  input  logic                       median_ready,
  output logic [mf3_pkg::PIX_W-1:0]  median_value,
  output logic [mf3_pkg::POS_W-1:0]  out_column,
  output logic [mf3_pkg::ROW_W-1:0]  out_row,
  output logic                       end_of_frame
);

  // compare-exchange: smaller value to index a
  function automatic mf3_pkg::taps_t cx(input mf3_pkg::taps_t t, input logic [3:0] a,
                                         input logic [3:0] b);
    mf3_pkg::taps_t r;
    r = t;
    if (t[a] > t[b]) begin
      r[a] = t[b];
      r[b] = t[a];
    end
    return r;
  endfunction

  // nineteen-exchange median network, three rounds per register level
  function automatic mf3_pkg::taps_t level1(input mf3_pkg::taps_t t);
    mf3_pkg::taps_t r;
    r = cx(cx(cx(t, 4'd1, 4'd2), 4'd4, 4'd5), 4'd7, 4'd8);
    r = cx(cx(cx(r, 4'd0, 4'd1), 4'd3, 4'd4), 4'd6, 4'd7);
    r = cx(cx(cx(r, 4'd1, 4'd2), 4'd4, 4'd5), 4'd7, 4'd8);
    return r;
  endfunction

  function automatic mf3_pkg::taps_t level2(input mf3_pkg::taps_t t);
    mf3_pkg::taps_t r;
    r = cx(cx(cx(t, 4'd0, 4'd3), 4'd5, 4'd8), 4'd4, 4'd7);
    r = cx(cx(cx(r, 4'd3, 4'd6), 4'd1, 4'd4), 4'd2, 4'd5);
    r = cx(r, 4'd4, 4'd7);
    return r;
  endfunction

  function automatic mf3_pkg::taps_t level3(input mf3_pkg::taps_t t);
    mf3_pkg::taps_t r;
    r = cx(t, 4'd4, 4'd2);
    r = cx(r, 4'd6, 4'd4);
    r = cx(r, 4'd4, 4'd2);
    return r;
  endfunction

  mf3_pkg::win_item_t s1, s2;
  mf3_pkg::taps_t     s3_taps;
  logic               s1_valid, s2_valid, s1_load, s2_load, out_load;

  assign out_load = !median_valid || median_ready;
  assign s2_load  = !s2_valid || out_load;
  assign s1_load  = !s1_valid || s2_load;
  assign q_pop    = q_valid && s1_load;
  assign s3_taps  = level3(s2.taps);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      median_valid <= 1'b0;
    end else begin
      if (s1_load) s1_valid <= q_valid;
      if (s2_load) s2_valid <= s1_valid;
      if (out_load) median_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1.taps   <= level1(q_item.taps);
      s1.column <= q_item.column;
      s1.row    <= q_item.row;
      s1.eof    <= q_item.eof;
    end
    if (s2_load) begin
      s2.taps   <= level2(s1.taps);
      s2.column <= s1.column;
      s2.row    <= s1.row;
      s2.eof    <= s1.eof;
    end
    if (out_load) begin
      median_value <= s3_taps[mf3_pkg::MEDIAN_RANK];
      out_column   <= s2.column;
      out_row      <= s2.row;
      end_of_frame <= s2.eof;
    end
  end

endmodule

@@ design/median_filter_3x3.sv @@
`timescale 1ns / 1ps

// channel    | direction | handshake                  | payload
// -----------+-----------+----------------------------+---------------------------------------
// pixel      | in        | pixel_valid / pixel_ready  | pixel_value, frame_start
// median     | out       | median_valid / median_ready| median_value, out_column, out_row,
//            |           |                            | end_of_frame
// cfg        | in        | cfg_write_enable           | cfg_index, cfg_data
//
// one pixel per clock while the queue is not full; a median passes hold, queue, sorter, output
// the line stores give one registered read and one write each per cycle, which sets the pace
// reset clears the position counters, window and pipeline; geometry returns to 640 x 480
// line stores are not cleared: an entry is only read after the row above has written it
// a stalled median output fills the sorter stages and a four-entry queue before pixel_ready drops

module median_filter_3x3 (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_enable,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mf3_pkg::DIM_W-1:0]         cfg_data,
  input  logic                              pixel_valid,
  output logic                              pixel_ready,
  input  logic [mf3_pkg::PIX_W-1:0]         pixel_value,
  input  logic                              frame_start,
  output logic                              median_valid,
  input  logic                              median_ready,
  output logic [mf3_pkg::PIX_W-1:0]         median_value,
  output logic [mf3_pkg::POS_W-1:0]         out_column,
  output logic [mf3_pkg::ROW_W-1:0]         out_row,
  output logic                              end_of_frame
);

  // geometry registers, to be written only while the block is idle; the block does not enforce it
  logic [mf3_pkg::DIM_W-1:0] image_width, image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= mf3_pkg::WIDTH_RESET;
      image_height <= mf3_pkg::HEIGHT_RESET;
    end else if (cfg_write_enable) begin
      case (mf3_pkg::cfg_reg_t'(cfg_index))
        mf3_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        mf3_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: position tracking, line stores and window; only full windows go on
  logic               push, queue_full, q_valid, q_pop;
  mf3_pkg::win_item_t push_item, q_item;

  mf3_front u_front (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel_value  (pixel_value),
    .frame_start  (frame_start),
    .push         (push),
    .push_item    (push_item),
    .queue_full   (queue_full)
  );

  // queue lets the front keep taking pixels while the sorter is held
  mf3_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop_valid (q_valid),
    .pop_item  (q_item),
    .pop       (q_pop)
  );

  // back: three-level median sorting network ending in the output register
  mf3_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .median_valid (median_valid),
    .median_ready (median_ready),
    .median_value (median_value),
    .out_column   (out_column),
    .out_row      (out_row),
    .end_of_frame (end_of_frame)
  );

endmodule

@@ bench/median_filter_3x3_checker.sv @@
`timescale 1ns / 1ps

module median_filter_3x3_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_enable,
  input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mf3_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          pixel_valid,
  input  logic                          pixel_ready,
  input  logic [mf3_pkg::PIX_W-1:0]     pixel_value,
  input  logic                          frame_start,
  input  logic                          median_valid,
  input  logic                          median_ready,
  input  logic [mf3_pkg::PIX_W-1:0]     median_value,
  input  logic [mf3_pkg::POS_W-1:0]     out_column,
  input  logic [mf3_pkg::ROW_W-1:0]     out_row,
  input  logic                          end_of_frame,
  output int                            failures,
  output int                            pending,
  output int                            checked
);

  typedef struct packed {
    logic [mf3_pkg::PIX_W-1:0] median;
    logic [mf3_pkg::POS_W-1:0] column;
    logic [mf3_pkg::ROW_W-1:0] row;
    logic                      eof;
  } median_result_t;

  // own copy of geometry, line stores, window and raster position
  logic [mf3_pkg::DIM_W-1:0] width_reg;
  logic [mf3_pkg::DIM_W-1:0] height_reg;
  logic [mf3_pkg::PIX_W-1:0] two_rows_up [mf3_pkg::MAX_WIDTH];
  logic [mf3_pkg::PIX_W-1:0] one_row_up  [mf3_pkg::MAX_WIDTH];
  logic [mf3_pkg::PIX_W-1:0] window_px   [6];
  int unsigned               col_pos;
  int unsigned               row_pos;

  median_result_t medians_due[$];
  int             fail_count  = 0;
  int             check_count = 0;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < mf3_pkg::MIN_DIM) return mf3_pkg::MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // rank by counting: the value with at most four below it and more than four at or below
  function automatic logic [mf3_pkg::PIX_W-1:0] median_of_nine(
      input logic [mf3_pkg::PIX_W-1:0] taps [mf3_pkg::TAPS]);
    int below;
    int at_most;
    median_of_nine = taps[0];
    for (int i = 0; i < mf3_pkg::TAPS; i++) begin
      below   = 0;
      at_most = 0;
      for (int j = 0; j < mf3_pkg::TAPS; j++) begin
        if (taps[j] < taps[i]) below++;
        if (taps[j] <= taps[i]) at_most++;
      end
      if (below <= mf3_pkg::MEDIAN_RANK && at_most > mf3_pkg::MEDIAN_RANK)
        median_of_nine = taps[i];
    end
  endfunction

  task automatic take_pixel(input logic [mf3_pkg::PIX_W-1:0] px, input logic fs);
    int unsigned               w;
    int unsigned               h;
    int unsigned               col;
    int unsigned               row;
    logic [mf3_pkg::PIX_W-1:0] above2;
    logic [mf3_pkg::PIX_W-1:0] above1;
    logic [mf3_pkg::PIX_W-1:0] taps [mf3_pkg::TAPS];
    median_result_t            res;
    w = clamp_dim(width_reg, mf3_pkg::MAX_WIDTH);
    h = clamp_dim(height_reg, mf3_pkg::MAX_HEIGHT);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    // a position past a shrunken edge counts as the last column or row
    col    = (col_pos > w - 1) ? w - 1 : col_pos;
    row    = (row_pos > h - 1) ? h - 1 : row_pos;
    above2 = two_rows_up[col];
    above1 = one_row_up[col];
    if (row >= 2 && col >= 2) begin
      for (int i = 0; i < 6; i++) taps[i] = window_px[i];
      taps[6]    = above2;
      taps[7]    = above1;
      taps[8]    = px;
      res.median = median_of_nine(taps);
      res.column = mf3_pkg::POS_W'(col - 2);
      res.row    = mf3_pkg::ROW_W'(row - 2);
      res.eof    = (col == w - 1) && (row == h - 1);
      medians_due.push_back(res);
    end
    two_rows_up[col] = above1;
    one_row_up[col]  = px;
    for (int i = 0; i < 3; i++) window_px[i] = window_px[i+3];
    window_px[3] = above2;
    window_px[4] = above1;
    window_px[5] = px;
    if (col == w - 1) begin
      col_pos = 0;
      row_pos = (row == h - 1) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    median_result_t want;
    if (rst) begin
      width_reg  = mf3_pkg::WIDTH_RESET;
      height_reg = mf3_pkg::HEIGHT_RESET;
      col_pos    = 0;
      row_pos    = 0;
      for (int i = 0; i < 6; i++) window_px[i] = '0;
      for (int i = 0; i < mf3_pkg::MAX_WIDTH; i++) begin
        two_rows_up[i] = '0;
        one_row_up[i]  = '0;
      end
      medians_due.delete();
    end else begin
      if (cfg_write_enable) begin
        case (mf3_pkg::cfg_reg_t'(cfg_index))
          mf3_pkg::REG_IMAGE_WIDTH:  width_reg = cfg_data;
          mf3_pkg::REG_IMAGE_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      // result side first, so a fresh expectation can never absorb a stray result
      if (median_valid && median_ready) begin
        if (medians_due.size() == 0) begin
          $display("%0t: unexpected median, expected none, actual %0d col %0d row %0d eof %0b",
                   $time, median_value, out_column, out_row, end_of_frame);
          fail_count++;
        end else begin
          want = medians_due.pop_front();
          check_field("median_value", want.median, median_value);
          check_field("out_column", want.column, out_column);
          check_field("out_row", want.row, out_row);
          check_field("end_of_frame", want.eof, end_of_frame);
          check_count++;
        end
      end
      if (pixel_valid && pixel_ready) take_pixel(pixel_value, frame_start);
    end
    failures <= fail_count;
    pending  <= medians_due.size();
    checked  <= check_count;
  end

endmodule

@@ bench/median_filter_3x3_tb.sv @@
`timescale 1ns / 1ps

module median_filter_3x3_tb;

  // how the pixels of one frame are drawn
  typedef enum int {
    PIX_UNIFORM,
    PIX_EXTREMES,
    PIX_CLUSTERED
  } pixel_mix_t;

  // shapes of one stretch of random stimulus
  typedef enum int {
    PHASE_FRAMES,
    PHASE_RESHAPE,
    PHASE_NOISE
  } phase_kind_t;

  localparam int RANDOM_PIXELS = 900;
  localparam int SETTLE_CYCLES = 16;    // hold, sorter and output registers plus the skid queue
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PRESS_WIDTH   = 40;    // wide enough that the receiver hold-off lands here
  localparam int PRESS_ROWS    = 10;

  logic                          clk              = 1'b0;
  logic                          rst              = 1'b1;
  logic                          cfg_write_enable = 1'b0;
  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index        = '0;
  logic [mf3_pkg::DIM_W-1:0]     cfg_data         = '0;
  logic                          pixel_valid      = 1'b0;
  logic [mf3_pkg::PIX_W-1:0]     pixel_value      = '0;
  logic                          frame_start      = 1'b0;
  logic                          median_ready     = 1'b0;
  logic                          pixel_ready;
  logic                          median_valid;
  logic [mf3_pkg::PIX_W-1:0]     median_value;
  logic [mf3_pkg::POS_W-1:0]     out_column;
  logic [mf3_pkg::ROW_W-1:0]     out_row;
  logic                          end_of_frame;

  int failures;
  int pending;
  int checked;

  int pixels_sent   = 0;
  int geometries    = 0;
  bit sender_brisk  = 1'b0;   // no gaps between pixel transfers
  bit receiver_brisk = 1'b0;  // no gaps between median transfers
  int cur_w;                  // effective geometry as last programmed
  int cur_h;

  always #5 clk = ~clk;

  median_filter_3x3 dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pixel_valid      (pixel_valid),
    .pixel_ready      (pixel_ready),
    .pixel_value      (pixel_value),
    .frame_start      (frame_start),
    .median_valid     (median_valid),
    .median_ready     (median_ready),
    .median_value     (median_value),
    .out_column       (out_column),
    .out_row          (out_row),
    .end_of_frame     (end_of_frame)
  );

  median_filter_3x3_checker median_check (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pixel_valid      (pixel_valid),
    .pixel_ready      (pixel_ready),
    .pixel_value      (pixel_value),
    .frame_start      (frame_start),
    .median_valid     (median_valid),
    .median_ready     (median_ready),
    .median_value     (median_value),
    .out_column       (out_column),
    .out_row          (out_row),
    .end_of_frame     (end_of_frame),
    .failures         (failures),
    .pending          (pending),
    .checked          (checked)
  );

  // register write: a one-cycle enable pulse, then enable low again before the task returns
  task automatic write_register(input mf3_pkg::cfg_reg_t idx, input int unsigned value);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= mf3_pkg::DIM_W'(value);
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    @(posedge clk);
  endtask

  // one pixel transfer: optional gap, then hold valid and payload until accepted
  task automatic send_pixel(input logic [mf3_pkg::PIX_W-1:0] px, input logic fs);
    int gap;
    gap = sender_brisk ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_value <= px;
    frame_start <= fs;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    pixels_sent++;
  endtask

  // sender pause: nothing offered until every due median has come out
  task automatic settle();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [mf3_pkg::PIX_W-1:0] draw_pixel(
      input pixel_mix_t mix, input logic [mf3_pkg::PIX_W-1:0] base);
    case (mix)
      PIX_EXTREMES:  return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      PIX_CLUSTERED: return base + mf3_pkg::PIX_W'($urandom_range(0, 3));  // many ties
      default:       return mf3_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // a run of raster pixels, frame_start only on the first if asked
  task automatic send_run(input int count, input bit first_fs, input pixel_mix_t mix);
    logic [mf3_pkg::PIX_W-1:0] base;
    base = mf3_pkg::PIX_W'($urandom_range(0, 255));
    for (int i = 0; i < count; i++) send_pixel(draw_pixel(mix, base), (i == 0) && first_fs);
  endtask

  // new geometry; values below the minimum are sometimes used to hit the clamp
  task automatic program_geometry(input int w, input int h);
    int raw_w;
    int raw_h;
    raw_w = (w == mf3_pkg::MIN_DIM && $urandom_range(0, 2) == 0) ? $urandom_range(0, 2) : w;
    raw_h = (h == mf3_pkg::MIN_DIM && $urandom_range(0, 2) == 0) ? $urandom_range(0, 2) : h;
    write_register(mf3_pkg::REG_IMAGE_WIDTH, raw_w);
    write_register(mf3_pkg::REG_IMAGE_HEIGHT, raw_h);
    cur_w = w;
    cur_h = h;
    geometries++;
  endtask

  // receiver: random gaps, bursts with none, and a long hold-off now and then
  initial begin : receiver
    int gap;
    int received;
    received = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (received % 64 == 0) receiver_brisk = ($urandom_range(0, 3) == 0);
      gap = receiver_brisk ? 0 : $urandom_range(0, 12);
      // long stall so the window pipeline and skid queue fill and pixel_ready drops
      if (received % 400 == 100) gap = 250;
      if (gap > 0) begin
        median_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      median_ready <= 1'b1;
      @(posedge clk);
      while (!median_valid) @(posedge clk);
      received++;
    end
  end

  initial begin : stimulus
    int          waited;
    int          w;
    int          h;
    int          frames;
    int          count;
    int          r;
    phase_kind_t kind;
    pixel_mix_t  mix;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: smallest frame, extreme pixels, wrap without frame_start, then a
    // partial frame that the next frame cuts off with frame_start
    write_register(mf3_pkg::REG_IMAGE_WIDTH, 3);
    write_register(mf3_pkg::REG_IMAGE_HEIGHT, 3);
    cur_w = 3;
    cur_h = 3;
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'h00 : 8'hFF, 1'b0);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'h7F, 1'b0);
    send_pixel(8'hFE, 1'b0);
    settle();

    // height register at its top (clamped), cut short after a few rows;
    // no sender gaps, so the receiver hold-off backs the pipe up
    write_register(mf3_pkg::REG_IMAGE_WIDTH, PRESS_WIDTH);
    write_register(mf3_pkg::REG_IMAGE_HEIGHT, 2047);
    cur_w = PRESS_WIDTH;
    cur_h = mf3_pkg::MAX_HEIGHT;
    sender_brisk = 1'b1;
    send_run(PRESS_WIDTH * PRESS_ROWS, 1'b1, PIX_UNIFORM);
    sender_brisk = 1'b0;

    // random stretches of well-formed frames, mid-frame reshapes and noise
    count = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < count) begin
      sender_brisk = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      kind = (r < 7) ? PHASE_FRAMES : (r < 9) ? PHASE_RESHAPE : PHASE_NOISE;
      if (cur_h > 12) kind = PHASE_FRAMES;
      r = $urandom_range(0, 2);
      mix = (r == 0) ? PIX_EXTREMES : (r == 1) ? PIX_CLUSTERED : PIX_UNIFORM;
      case (kind)
        PHASE_FRAMES: begin
          settle();
          r = $urandom_range(0, 9);
          w = (r == 0) ? mf3_pkg::MIN_DIM :
              (r == 1) ? $urandom_range(13, 40) : $urandom_range(3, 12);
          h = ($urandom_range(0, 4) == 0) ? mf3_pkg::MIN_DIM : $urandom_range(3, 8);
          program_geometry(w, h);
          frames = $urandom_range(1, 3);
          for (int f = 0; f < frames; f++) begin
            // last frame sometimes cut short; later frames sometimes wrap on their own
            if (f == frames - 1 && $urandom_range(0, 4) == 0) send_run(
                $urandom_range(1, w * h - 1), (f == 0) || ($urandom_range(0, 1) != 0), mix);
            else send_run(w * h, (f == 0) || ($urandom_range(0, 1) != 0), mix);
          end
        end
        PHASE_RESHAPE: begin
          // part of a frame, then a width no wider than before or a height of 3 to 10 takes effect mid-frame
          send_run($urandom_range(1, cur_w * cur_h - 1), 1'b1, mix);
          settle();
          if ($urandom_range(0, 1) != 0) begin
            cur_w = $urandom_range(mf3_pkg::MIN_DIM, cur_w);
            write_register(mf3_pkg::REG_IMAGE_WIDTH, cur_w);
          end else begin
            cur_h = $urandom_range(mf3_pkg::MIN_DIM, 10);
            write_register(mf3_pkg::REG_IMAGE_HEIGHT, cur_h);
          end
          send_run($urandom_range(1, cur_w * cur_h), 1'b0, mix);
        end
        default: begin
          // stray frame_start marks scattered through the stream
          repeat ($urandom_range(10, 40))
            send_pixel(draw_pixel(mix, 8'h00), $urandom_range(0, 7) == 0);
        end
      endcase
    end

    // wait for the last medians, bounded
    pixel_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending != 0) $display("%0t: %0d expected medians never arrived", $time, pending);
    $display("covered %0d pixel transfers and %0d checked medians over %0d random geometries,",
             pixels_sent, checked, geometries);
    $display("plus the smallest frame, a clamped height, wraps, restarts and reshapes");
    if (failures == 0 && pending == 0) begin
      $display("[median_filter_3x3] OK");
    end else begin
      $display("[median_filter_3x3] ERROR");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #10_000_000;
    $display("%0t: run did not complete in time, %0d medians still due", $time, pending);
    $display("[median_filter_3x3] ERROR");
    $finish;
  end

endmodule
